FILE: rtl/kcd_pkg.sv
`default_nettype none

package kcd_pkg;

  localparam int Rows      = 8;
  localparam int Cols      = 16;
  localparam int MaxCombos = 6;
  localparam int TimeBits  = 32;

  localparam int KeyDepth = Rows * Cols;
  localparam int KeyIdxW  = $clog2(KeyDepth);
  localparam int SelW     = (MaxCombos > 1) ? $clog2(MaxCombos) : 1;

  localparam int RowW     = 3;
  localparam int ColW     = 4;
  localparam int StampW   = 32;
  localparam int EligW    = 6;
  localparam int CodeW    = 16;
  localparam int WindowW  = 32;
  localparam int CntW     = 3;
  localparam int ComboW   = 30;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [WindowW-1:0] WindowReset = 32'd50;

  localparam logic [CfgIdxW-1:0] CfgWindow = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCount  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCombo0 = 3'd2;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [KeyIdxW-1:0]  key_idx_t;

  typedef struct packed {
    logic [RowW-1:0]   key_row;
    logic [ColW-1:0]   key_col;
    logic              is_press;
    logic [StampW-1:0] event_time;
    logic [EligW-1:0]  combo_eligible;
  } in_t;

  typedef struct packed {
    logic             consumed;
    logic             emit_valid;
    logic [CodeW-1:0] action_code;
    logic             action_pressed;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ColW-1:0]  b_col;
    logic [RowW-1:0]  b_row;
    logic [ColW-1:0]  a_col;
    logic [RowW-1:0]  a_row;
  } combo_t;

  typedef struct packed {
    logic     en;
    key_idx_t idx;
    time_t    stamp;
  } press_t;

  typedef struct packed {
    time_t ta;
    time_t tb;
  } shadow_t;

  function automatic logic key_in_range(logic [RowW-1:0] row, logic [ColW-1:0] col);
    return (32'(row) < Rows) && (32'(col) < Cols);
  endfunction

  function automatic key_idx_t key_index(logic [RowW-1:0] row, logic [ColW-1:0] col);
    return KeyIdxW'(32'(row) * Cols + 32'(col));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kcd_time_store.sv
`default_nettype none

module kcd_time_store (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  kcd_pkg::combo_t  [kcd_pkg::MaxCombos-1:0] combos_i,
  input  logic             [kcd_pkg::MaxCombos-1:0] combo_wr_i,
  input  logic                                     hold_i,
  input  kcd_pkg::press_t                          press_i,
  output kcd_pkg::shadow_t [kcd_pkg::MaxCombos-1:0] shadow_o,
  output logic                                     busy_o
);

  typedef enum logic [2:0] {
    RefIdle = 3'b001,
    RefRead = 3'b010,
    RefLoad = 3'b100
  } ref_state_e;

  ref_state_e state_q, state_d;

  kcd_pkg::time_t                         time_mem_q [kcd_pkg::KeyDepth];
  logic            [kcd_pkg::KeyDepth-1:0] key_vld_q;
  kcd_pkg::shadow_t [kcd_pkg::MaxCombos-1:0] shadow_q;

  logic [kcd_pkg::MaxCombos-1:0] pend_q, pend_d, pend_clr;
  logic [kcd_pkg::SelW-1:0]      sel_q, first_sel;

  kcd_pkg::time_t rd_a_q, rd_b_q;
  logic           va_q, vb_q;

  kcd_pkg::combo_t   sel_combo;
  kcd_pkg::key_idx_t a_idx, b_idx;
  logic              a_in, b_in;

  assign sel_combo = combos_i[sel_q];
  assign a_idx     = kcd_pkg::key_index(sel_combo.a_row, sel_combo.a_col);
  assign b_idx     = kcd_pkg::key_index(sel_combo.b_row, sel_combo.b_col);
  assign a_in      = kcd_pkg::key_in_range(sel_combo.a_row, sel_combo.a_col);
  assign b_in      = kcd_pkg::key_in_range(sel_combo.b_row, sel_combo.b_col);

  always_comb begin
    first_sel = '0;
    for (int i = kcd_pkg::MaxCombos - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        first_sel = kcd_pkg::SelW'(i);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    pend_clr = '0;
    unique case (state_q)
      RefIdle: begin
        if ((pend_q != '0) && !hold_i) begin
          state_d = RefRead;
        end
      end
      RefRead: begin
        state_d = RefLoad;
      end
      RefLoad: begin
        pend_clr[sel_q] = 1'b1;
        state_d         = RefIdle;
      end
      default: begin
        state_d = RefIdle;
      end
    endcase
    pend_d = (pend_q & ~pend_clr) | combo_wr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RefIdle;
      pend_q  <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (state_q == RefIdle) begin
        sel_q <= first_sel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q <= '0;
    end else if (press_i.en) begin
      key_vld_q[press_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (press_i.en) begin
      time_mem_q[press_i.idx] <= press_i.stamp;
    end
    if (state_q == RefRead) begin
      rd_a_q <= time_mem_q[a_idx];
      rd_b_q <= time_mem_q[b_idx];
      va_q   <= a_in && key_vld_q[a_idx];
      vb_q   <= b_in && key_vld_q[b_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q <= '0;
    end else begin
      for (int i = 0; i < kcd_pkg::MaxCombos; i++) begin
        if (press_i.en
            && kcd_pkg::key_in_range(combos_i[i].a_row, combos_i[i].a_col)
            && (kcd_pkg::key_index(combos_i[i].a_row, combos_i[i].a_col)
                == press_i.idx)) begin
          shadow_q[i].ta <= press_i.stamp;
        end
        if (press_i.en
            && kcd_pkg::key_in_range(combos_i[i].b_row, combos_i[i].b_col)
            && (kcd_pkg::key_index(combos_i[i].b_row, combos_i[i].b_col)
                == press_i.idx)) begin
          shadow_q[i].tb <= press_i.stamp;
        end
      end
      if (state_q == RefLoad) begin
        shadow_q[sel_q].ta <= va_q ? rd_a_q : '0;
        shadow_q[sel_q].tb <= vb_q ? rd_b_q : '0;
      end
    end
  end

  assign shadow_o = shadow_q;
  assign busy_o   = (pend_q != '0) || (state_q != RefIdle);

endmodule

`default_nettype wire

FILE: rtl/key_combo_detector.sv
`default_nettype none

// Two-key combo detector. Each key event passes an input register and then a
// result register; one event is taken per cycle unless a reload, a stalled
// output or a pending tap holds it back. A release, or a press that completes
// no combo, gives one empty result; a press that completes a combo gives a tap
// (press result, then release result), and no new event is taken until the
// press result has left the single result register. Press times live in a
// 128 x 32 memory with per-key valid bits cleared by reset; each combo keeps a
// copy of its two members' times. Writing a combo register reloads that copy
// from the memory via states RefRead and RefLoad, one combo at a time; input
// transfers are stalled until every rewritten combo is reloaded.
module key_combo_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic            [kcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic            [kcd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  kcd_pkg::in_t                         in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output kcd_pkg::out_t                        out_data_o
);

  logic [kcd_pkg::WindowW-1:0] window_q;
  logic [kcd_pkg::CntW-1:0]    count_q, count_eff;
  kcd_pkg::combo_t [kcd_pkg::MaxCombos-1:0] combo_q;
  logic            [kcd_pkg::MaxCombos-1:0] combo_wr;

  logic          in_valid_q, in_valid_d;
  kcd_pkg::in_t  in_q;
  logic          out_valid_q, out_valid_d;
  logic          second_q, second_d;
  kcd_pkg::out_t out_q;

  logic in_xfer, adv, out_free, busy;

  kcd_pkg::press_t                           press;
  kcd_pkg::shadow_t [kcd_pkg::MaxCombos-1:0] shadow;

  kcd_pkg::time_t now;
  kcd_pkg::time_t oth_t [kcd_pkg::MaxCombos];
  kcd_pkg::time_t dt    [kcd_pkg::MaxCombos];
  logic [kcd_pkg::MaxCombos-1:0] hit, is_a, is_b, o_same, o_in;
  logic [kcd_pkg::RowW-1:0] o_row [kcd_pkg::MaxCombos];
  logic [kcd_pkg::ColW-1:0] o_col [kcd_pkg::MaxCombos];
  logic                     fire;
  logic [kcd_pkg::CodeW-1:0] fire_code;

  always_comb begin
    for (int i = 0; i < kcd_pkg::MaxCombos; i++) begin
      combo_wr[i] = cfg_we_i
                    && (cfg_idx_i == kcd_pkg::CfgCombo0 + kcd_pkg::CfgIdxW'(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= kcd_pkg::WindowReset;
      count_q  <= '0;
      combo_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kcd_pkg::CfgWindow: window_q <= cfg_wdata_i[kcd_pkg::WindowW-1:0];
        kcd_pkg::CfgCount:  count_q  <= cfg_wdata_i[kcd_pkg::CntW-1:0];
        default: begin
          for (int i = 0; i < kcd_pkg::MaxCombos; i++) begin
            if (combo_wr[i]) begin
              combo_q[i] <= cfg_wdata_i[kcd_pkg::ComboW-1:0];
            end
          end
        end
      endcase
    end
  end

  assign count_eff = (32'(count_q) > kcd_pkg::MaxCombos)
                     ? kcd_pkg::CntW'(kcd_pkg::MaxCombos) : count_q;

  assign out_free   = !out_valid_q || (!out_stall_i && !second_q);
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = busy || (in_valid_q && !adv);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign now = in_q.event_time[kcd_pkg::TimeBits-1:0];

  always_comb begin
    for (int i = 0; i < kcd_pkg::MaxCombos; i++) begin
      is_a[i]   = (combo_q[i].a_row == in_q.key_row) && (combo_q[i].a_col == in_q.key_col);
      is_b[i]   = (combo_q[i].b_row == in_q.key_row) && (combo_q[i].b_col == in_q.key_col);
      o_row[i]  = is_a[i] ? combo_q[i].b_row : combo_q[i].a_row;
      o_col[i]  = is_a[i] ? combo_q[i].b_col : combo_q[i].a_col;
      o_in[i]   = kcd_pkg::key_in_range(o_row[i], o_col[i]);
      o_same[i] = (o_row[i] == in_q.key_row) && (o_col[i] == in_q.key_col);
      if (!o_in[i]) begin
        oth_t[i] = '0;
      end else if (o_same[i]) begin
        oth_t[i] = now;
      end else begin
        oth_t[i] = is_a[i] ? shadow[i].tb : shadow[i].ta;
      end
      dt[i]  = now - oth_t[i];
      hit[i] = in_q.is_press && (32'(i) < 32'(count_eff)) && in_q.combo_eligible[i]
               && (is_a[i] || is_b[i]) && (oth_t[i] != '0)
               && (kcd_pkg::WindowW'(dt[i]) <= window_q);
    end
  end

  always_comb begin
    fire      = 1'b0;
    fire_code = '0;
    for (int i = kcd_pkg::MaxCombos - 1; i >= 0; i--) begin
      if (hit[i]) begin
        fire      = 1'b1;
        fire_code = combo_q[i].code;
      end
    end
  end

  assign press.en    = adv && in_q.is_press && kcd_pkg::key_in_range(in_q.key_row, in_q.key_col);
  assign press.idx   = kcd_pkg::key_index(in_q.key_row, in_q.key_col);
  assign press.stamp = now;

  kcd_time_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .combos_i   (combo_q),
    .combo_wr_i (combo_wr),
    .hold_i     (in_valid_q),
    .press_i    (press),
    .shadow_o   (shadow),
    .busy_o     (busy)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    second_d    = second_q;
    if (adv) begin
      out_valid_d = 1'b1;
      second_d    = fire;
    end else if (out_valid_q && !out_stall_i) begin
      if (second_q) begin
        second_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q.consumed       <= fire;
      out_q.emit_valid     <= fire;
      out_q.action_code    <= fire_code;
      out_q.action_pressed <= fire;
      out_q.last           <= !fire;
    end else if (out_valid_q && !out_stall_i && second_q) begin
      out_q.action_pressed <= 1'b0;
      out_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
